>>> hw/rtl/u8u16_pkg.sv
package u8u16_pkg;

    // Byte classes taken from the top five bits of an input byte.
    localparam logic [2:0] KIND_CONT  = 3'd0;
    localparam logic [2:0] KIND_ASCII = 3'd1;
    localparam logic [2:0] KIND_LEAD2 = 3'd2;
    localparam logic [2:0] KIND_LEAD3 = 3'd3;
    localparam logic [2:0] KIND_LEAD4 = 3'd4;
    localparam logic [2:0] KIND_BAD   = 3'd5;

    localparam logic [15:0] UNIT_QMARK    = 16'h003F;
    localparam logic [15:0] UNIT_HI_BASE  = 16'hD800;
    localparam logic [15:0] UNIT_LO_BASE  = 16'hDC00;
    localparam logic [20:0] CP_SUPP_BASE  = 21'h010000;

    // Up to four code units produced by one byte, in order.
    typedef struct packed {
        logic [3:0][15:0] units;
        logic [2:0]       count;
        logic             str_end;
    } burst_t;

    // Sequence state of the decoder, visible for checking.
    typedef struct packed {
        logic [1:0] need;
        logic [1:0] held;
    } front_stat_t;

endpackage

>>> hw/rtl/utf8_to_utf16_transcoder.sv
// The first code unit of a byte reaches the output through the queue memory and
// then the output register; further units of the same byte follow one per cycle
// while m_ready is high. The decoder takes one byte per cycle while the queue is
// not full, and the output moves one code unit per cycle while m_ready is high.
// Reset: aresetn is synchronous and active low; it clears the sequence state,
// the queue and the output valid flag.
module utf8_to_utf16_transcoder
    import u8u16_pkg::*;
#(
    parameter int FIFO_DEPTH = 4
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_string_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic        m_run_last,
    output logic        m_string_done
);

    // Front decodes each byte into a burst of up to four code units.
    logic        q_full;
    logic        q_push;
    burst_t      q_wdata;
    front_stat_t stat;

    // Queue between decoder and serializer.
    logic        q_valid;
    logic        q_pop;
    burst_t      q_head;

    u8u16_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_in_byte    (s_in_byte),
        .s_string_end (s_string_end),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_burst      (q_wdata),
        .stat         (stat)
    );

    // Bursts wait here so the decoder keeps taking bytes while the output drains.
    u8u16_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .head      (q_head)
    );

    // Back end: walk each burst one word at a time into the output register.
    u8u16_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (q_valid),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_unit   (m_code_unit),
        .m_run_last    (m_run_last),
        .m_string_done (m_string_done)
    );

`ifndef ASSERT_OFF
    // A string end always leaves no sequence open.
    a_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_string_end) |=> (stat.need == 2'd0 && stat.held == 2'd0))
        else $error("sequence state not cleared after string end");

    // An open sequence always holds at least its lead byte.
    a_open_held: assert property (@(posedge aclk) disable iff (!aresetn)
        (stat.need != 2'd0) |-> (stat.held != 2'd0))
        else $error("open sequence with no held bytes");

    // The last word of a string is also the last word of its byte.
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_string_done) |-> m_run_last)
        else $error("string_done without run_last");

    // Never pop an empty queue.
    a_pop_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_valid)
        else $error("queue popped while empty");
`endif

endmodule

>>> hw/rtl/u8u16_front.sv
module u8u16_front
    import u8u16_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_string_end,
    input  logic        q_full,
    output logic        q_push,
    output burst_t      q_burst,
    output front_stat_t stat
);

    logic [20:0] cp_reg,   cp_next;
    logic [1:0]  need_reg, need_next;
    logic [1:0]  held_reg, held_next;

    logic [2:0]  kind;
    logic        take;
    logic [20:0] cp_shift;
    logic [20:0] cp_off;
    logic [1:0]  need_dec;
    logic [1:0]  held_inc;
    logic [2:0]  qcnt;
    logic [1:0]  tail_n;
    logic [15:0] tail0;
    logic [15:0] tail1;
    logic [2:0]  count;

    always_comb begin
        unique case (s_in_byte[7:3]) inside
            5'b0????: kind = KIND_ASCII;
            5'b10???: kind = KIND_CONT;
            5'b110??: kind = KIND_LEAD2;
            5'b1110?: kind = KIND_LEAD3;
            5'b11110: kind = KIND_LEAD4;
            default:  kind = KIND_BAD;
        endcase
    end

    assign s_ready  = !q_full;
    assign take     = s_valid && s_ready;
    assign cp_shift = {cp_reg[14:0], s_in_byte[5:0]};
    assign cp_off   = cp_shift - CP_SUPP_BASE;
    assign need_dec = need_reg - 2'd1;
    assign held_inc = held_reg + 2'd1;

    always_comb begin
        cp_next   = cp_reg;
        need_next = need_reg;
        held_next = held_reg;
        qcnt      = 3'd0;
        tail_n    = 2'd0;
        tail0     = UNIT_QMARK;
        tail1     = UNIT_QMARK;
        if (need_reg != 2'd0 && kind == KIND_CONT) begin
            if (need_dec == 2'd0) begin
                // Sequence complete: one unit or a surrogate pair.
                if (cp_shift < CP_SUPP_BASE) begin
                    tail_n = 2'd1;
                    tail0  = cp_shift[15:0];
                end else begin
                    tail_n = 2'd2;
                    tail0  = UNIT_HI_BASE + {5'd0, cp_off[20:10]};
                    tail1  = UNIT_LO_BASE | {6'd0, cp_off[9:0]};
                end
                cp_next   = '0;
                need_next = 2'd0;
                held_next = 2'd0;
            end else if (s_string_end) begin
                qcnt      = {1'b0, held_inc};
                cp_next   = '0;
                need_next = 2'd0;
                held_next = 2'd0;
            end else begin
                cp_next   = cp_shift;
                need_next = need_dec;
                held_next = held_inc;
            end
        end else begin
            // Flush a broken sequence, then handle the byte afresh.
            if (need_reg != 2'd0) begin
                qcnt = {1'b0, held_reg};
            end
            cp_next   = '0;
            need_next = 2'd0;
            held_next = 2'd0;
            unique case (kind)
                KIND_ASCII: begin
                    tail_n = 2'd1;
                    tail0  = {8'd0, s_in_byte};
                end
                KIND_LEAD2, KIND_LEAD3, KIND_LEAD4: begin
                    if (s_string_end) begin
                        qcnt = qcnt + 3'd1;
                    end else begin
                        need_next = kind[1:0] - 2'd1;
                        held_next = 2'd1;
                        if (kind == KIND_LEAD2) begin
                            cp_next = {16'd0, s_in_byte[4:0]};
                        end else if (kind == KIND_LEAD3) begin
                            cp_next = {17'd0, s_in_byte[3:0]};
                        end else begin
                            cp_next = {18'd0, s_in_byte[2:0]};
                        end
                    end
                end
                default: begin
                    tail_n = 2'd1;
                end
            endcase
        end
    end

    assign count = qcnt + {1'b0, tail_n};

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            if (3'(i) < qcnt) begin
                q_burst.units[i] = UNIT_QMARK;
            end else if (3'(i) - qcnt == 3'd0) begin
                q_burst.units[i] = tail0;
            end else begin
                q_burst.units[i] = tail1;
            end
        end
        q_burst.count   = count;
        q_burst.str_end = s_string_end;
    end

    assign q_push = take && (count != 3'd0);

    assign stat.need = need_reg;
    assign stat.held = held_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cp_reg   <= '0;
            need_reg <= 2'd0;
            held_reg <= 2'd0;
        end else if (take) begin
            cp_reg   <= cp_next;
            need_reg <= need_next;
            held_reg <= held_next;
        end
    end

endmodule

>>> hw/rtl/u8u16_fifo.sv
module u8u16_fifo
    import u8u16_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  burst_t push_data,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output burst_t head
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    burst_t        mem [DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0] level_reg;

    assign full      = (level_reg == CW'(DEPTH));
    assign not_empty = (level_reg != '0);
    assign head      = mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                level_reg <= level_reg + 1'b1;
            end else if (pop && !push) begin
                level_reg <= level_reg - 1'b1;
            end
        end
    end

endmodule

>>> hw/rtl/u8u16_back.sv
module u8u16_back
    import u8u16_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    input  burst_t      q_head,
    output logic        q_pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_code_unit,
    output logic        m_run_last,
    output logic        m_string_done
);

    logic [1:0]  idx_reg;
    logic        m_valid_reg;
    logic [15:0] unit_reg;
    logic        last_reg;
    logic        done_reg;
    logic        emit;
    logic        last;

    assign emit  = q_valid && (!m_valid_reg || m_ready);
    assign last  = ({1'b0, idx_reg} + 3'd1) == q_head.count;
    assign q_pop = emit && last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg     <= 2'd0;
            m_valid_reg <= 1'b0;
        end else begin
            if (emit) begin
                idx_reg <= last ? 2'd0 : idx_reg + 2'd1;
            end
            if (emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (emit) begin
            unit_reg <= q_head.units[idx_reg];
            last_reg <= last;
            done_reg <= last && q_head.str_end;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_code_unit   = unit_reg;
    assign m_run_last    = last_reg;
    assign m_string_done = done_reg;

endmodule

>>> verif/utf8_to_utf16_transcoder_tb.sv
module utf8_to_utf16_transcoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import u8u16_pkg::*;

    // Stop the run if no word moves on either channel for this many cycles.
    localparam int QUIET_LIMIT = 2000;
    // Print at most this many mismatch lines; keep counting past it.
    localparam int MAX_REPORTS = 40;

    // One predicted code unit word, with both flags.
    typedef struct packed {
        logic [15:0] code_unit;
        logic        run_last;
        logic        string_done;
    } unit_word_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        s_string_end;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_code_unit;
    logic        m_run_last;
    logic        m_string_done;

    // Predicted code units, oldest first.
    unit_word_t  units_due[$];
    // Units produced by the byte under prediction.
    logic [15:0] step_units[$];
    unit_word_t  unit_head;

    // Shadow of the decoder's open sequence.
    logic [20:0] cp_acc;
    logic [1:0]  cont_need;
    logic [1:0]  cont_held;

    int src_idle_pct;
    int snk_stall_pct;
    int hold_cycles;
    int bytes_sent;
    int strings_closed;
    int units_checked;
    int error_count;

    utf8_to_utf16_transcoder dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_in_byte     (s_in_byte),
        .s_string_end  (s_string_end),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_code_unit   (m_code_unit),
        .m_run_last    (m_run_last),
        .m_string_done (m_string_done)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Predictor: a byte-by-byte UTF-8 decoder that emits UTF-16 units.
    // ------------------------------------------------------------------

    // Class a byte by its top five bits.
    function automatic logic [2:0] classify_byte(input logic [7:0] b);
        casez (b)
            8'b0???????: return KIND_ASCII;
            8'b10??????: return KIND_CONT;
            8'b110?????: return KIND_LEAD2;
            8'b1110????: return KIND_LEAD3;
            8'b11110???: return KIND_LEAD4;
            default:     return KIND_BAD;
        endcase
    endfunction

    // Drop anything past four units; one byte never produces more.
    function automatic void push_unit(input logic [15:0] cu);
        if (step_units.size() < 4)
            step_units.push_back(cu);
    endfunction

    function automatic void clear_seq();
        cp_acc    = '0;
        cont_need = '0;
        cont_held = '0;
    endfunction

    // Replace every held byte of an abandoned sequence with a question mark.
    function automatic void flush_held();
        int i;
        for (i = 0; i < int'(cont_held); i++)
            push_unit(UNIT_QMARK);
        clear_seq();
    endfunction

    // Advance the shadow decoder by one accepted byte and queue its units.
    function automatic void transcode_byte(input logic [7:0] b, input logic last);
        logic [2:0]  cls;
        logic        fresh;
        logic [20:0] ofs;
        unit_word_t  w;
        step_units.delete();
        cls   = classify_byte(b);
        fresh = 1'b1;
        if (cont_need != 2'd0) begin
            if (cls == KIND_CONT) begin
                // Shift the continuation payload into the open codepoint.
                fresh     = 1'b0;
                cp_acc    = {cp_acc[14:0], b[5:0]};
                cont_held = cont_held + 2'd1;
                cont_need = cont_need - 2'd1;
                if (cont_need == 2'd0) begin
                    if (cp_acc < CP_SUPP_BASE) begin
                        push_unit(cp_acc[15:0]);
                    end else begin
                        // Split a supplementary codepoint into a surrogate pair.
                        ofs = cp_acc - CP_SUPP_BASE;
                        push_unit(UNIT_HI_BASE + {5'd0, ofs[20:10]});
                        push_unit(UNIT_LO_BASE + {6'd0, ofs[9:0]});
                    end
                    clear_seq();
                end else if (last) begin
                    flush_held();
                end
            end else begin
                // A non-continuation breaks the sequence; then decode it afresh.
                flush_held();
            end
        end
        if (fresh) begin
            case (cls)
                KIND_ASCII:          push_unit({8'd0, b});
                KIND_CONT, KIND_BAD: push_unit(UNIT_QMARK);
                default: begin
                    if (cls == KIND_LEAD2)
                        cp_acc = {16'd0, b[4:0]};
                    else if (cls == KIND_LEAD3)
                        cp_acc = {17'd0, b[3:0]};
                    else
                        cp_acc = {18'd0, b[2:0]};
                    cont_need = 2'(cls - 3'd1);
                    cont_held = 2'd1;
                    if (last)
                        flush_held();
                end
            endcase
        end
        if (last)
            clear_seq();
        foreach (step_units[i]) begin
            w.code_unit   = step_units[i];
            w.run_last    = (i == step_units.size() - 1);
            w.string_done = last && (i == step_units.size() - 1);
            units_due.push_back(w);
        end
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offer one byte, idling first at the current rate, and hold it until taken.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            @(negedge aclk);
            s_valid <= 1'b0;
        end
        @(negedge aclk);
        s_valid      <= 1'b1;
        s_in_byte    <= b;
        s_string_end <= last;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        transcode_byte(b, last);
        bytes_sent++;
        if (last)
            strings_closed++;
    endtask

    // Drop valid and hold off until every predicted unit has come out.
    task automatic pause_until_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (units_due.size() != 0)
            @(posedge aclk);
    endtask

    // Send one random sequence: mostly well-formed UTF-8, some cut short,
    // some stray continuations, and a little raw noise.
    task automatic send_random_seq();
        logic [7:0] seq[$];
        int         pick;
        int         len;
        int         keep;
        logic       last;
        pick = $urandom_range(99);
        len  = $urandom_range(1, 4);
        if (pick < 90) begin
            case (len)
                1:       seq.push_back({1'b0, 7'($urandom)});
                2:       seq.push_back({3'b110, 5'($urandom)});
                3:       seq.push_back({4'b1110, 4'($urandom)});
                default: seq.push_back({5'b11110, 3'($urandom)});
            endcase
            keep = len - 1;
            if (pick >= 78 && len > 1)
                keep = $urandom_range(0, len - 2);
            repeat (keep)
                seq.push_back({2'b10, 6'($urandom)});
        end else if (pick < 95) begin
            repeat ($urandom_range(1, 3))
                seq.push_back({2'b10, 6'($urandom)});
        end else begin
            seq.push_back(8'($urandom));
        end
        // Close strings mostly on sequence boundaries, now and then mid-sequence.
        foreach (seq[i]) begin
            if (i == seq.size() - 1)
                last = ($urandom_range(9) == 0);
            else
                last = ($urandom_range(39) == 0);
            send_byte(seq[i], last);
        end
    endtask

    // ------------------------------------------------------------------
    // Output side
    // ------------------------------------------------------------------

    // Stall at the current rate; a pending hold-off forces ready low, counted here.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                hold_cycles = hold_cycles - 1;
            end else begin
                m_ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    function automatic void flag_mismatch(input string what, input logic [15:0] want,
                                          input logic [15:0] got);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, what, want, got);
    endfunction

    // Check each accepted word against the oldest prediction.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (units_due.size() == 0) begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t ns: unexpected word, expected none, got %h last=%b done=%b",
                             $time, m_code_unit, m_run_last, m_string_done);
            end else begin
                unit_head = units_due.pop_front();
                if (m_code_unit !== unit_head.code_unit)
                    flag_mismatch("code_unit", unit_head.code_unit, m_code_unit);
                if (m_run_last !== unit_head.run_last)
                    flag_mismatch("run_last", {15'd0, unit_head.run_last},
                                  {15'd0, m_run_last});
                if (m_string_done !== unit_head.string_done)
                    flag_mismatch("string_done", {15'd0, unit_head.string_done},
                                  {15'd0, m_string_done});
                units_checked++;
            end
        end
    end

    // Watchdog: end the run if traffic stops on both channels.
    initial begin : watchdog
        int quiet;
        quiet = 0;
        @(posedge aresetn);
        while (quiet < QUIET_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("%0t ns: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Pass the bottom and top of the ASCII range straight through.
    task automatic test_ascii_edges();
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b0);
    endtask

    // Decode each sequence length, including a surrogate pair and the
    // largest codepoint a four-byte lead can carry.
    task automatic test_multibyte();
        send_byte(8'hC3, 1'b0);
        send_byte(8'hA9, 1'b0);
        send_byte(8'hE2, 1'b0);
        send_byte(8'h82, 1'b0);
        send_byte(8'hAC, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b0);
        send_byte(8'h98, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hF7, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b0);
        send_byte(8'hBF, 1'b1);
    endtask

    // Replace a stray continuation and both ends of the bad lead range.
    task automatic test_invalid_bytes();
        send_byte(8'h80, 1'b0);
        send_byte(8'hF8, 1'b0);
        send_byte(8'hFF, 1'b0);
    endtask

    // Break an open sequence with ASCII (four units from one byte), cut one
    // short at the string end, and end a string right on a lead.
    task automatic test_broken_sequences();
        send_byte(8'hF0, 1'b0);
        send_byte(8'h90, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h41, 1'b0);
        send_byte(8'hF0, 1'b0);
        send_byte(8'h9F, 1'b1);
        send_byte(8'hC3, 1'b1);
        pause_until_drained();
    endtask

    // Run random traffic under one idle mix until enough bytes went in.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int goal);
        int target;
        src_idle_pct  = idle_pct;
        snk_stall_pct = stall_pct;
        target        = bytes_sent + goal;
        while (bytes_sent < target)
            send_random_seq();
    endtask

    // Hold the output off for a long stretch while bytes keep coming, so the
    // queue fills and the input stalls; then drain everything.
    task automatic test_backpressure();
        int target;
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_cycles   = 80;
        target        = bytes_sent + 24;
        while (bytes_sent < target)
            send_random_seq();
        pause_until_drained();
    endtask

    initial begin
        aresetn        = 1'b0;
        s_valid        = 1'b0;
        s_in_byte      = 8'h00;
        s_string_end   = 1'b0;
        src_idle_pct   = 0;
        snk_stall_pct  = 0;
        hold_cycles    = 0;
        bytes_sent     = 0;
        strings_closed = 0;
        units_checked  = 0;
        error_count    = 0;
        clear_seq();

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_ascii_edges();
        test_multibyte();
        test_invalid_bytes();
        test_broken_sequences();
        test_random_traffic(0, 0, 100);
        test_random_traffic(57, 0, 100);
        test_random_traffic(0, 57, 100);
        test_random_traffic(35, 35, 100);
        test_backpressure();

        // Settle: let any straggling word surface before judging.
        snk_stall_pct = 0;
        pause_until_drained();
        repeat (16) @(posedge aclk);

        $display("Covered %0d bytes in %0d closed strings; %0d code units checked",
                 bytes_sent, strings_closed, units_checked);
        $display("under four idle mixes and an 80-cycle output hold-off.");
        if (error_count == 0 && units_due.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
